// File: sv/rfb_pkg.sv
// Shared constants, control word types and the microcode table of the resonator filter bank.
package rfb_pkg;

  localparam int MAX_FILTERS_DEF = 10;
  localparam int COEF_WORDS      = 5;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 64;
  localparam int SAMPLE_W        = 16;
  localparam int DELAY_W         = 32;
  localparam int COEF_W          = 16;
  localparam int PROD_W          = COEF_W + DELAY_W;
  localparam int ACC_W           = PROD_W + 2;
  localparam int FRAC_SHIFT      = 14;
  localparam int ROUND_CONST     = 8192;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_FIRST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_LAST    = 3'd5;

  typedef logic [1:0] pc_t;

  localparam pc_t STEP_WAIT = 2'd0;
  localparam pc_t STEP_MUL  = 2'd1;
  localparam pc_t STEP_UPD  = 2'd2;
  localparam pc_t STEP_EMIT = 2'd3;

  typedef enum logic [1:0] {
    COND_NEXT,
    COND_ACCEPT,
    COND_LOOP,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    logic  take_in;
    logic  do_mul;
    logic  do_upd;
    logic  do_emit;
    cond_t cond;
    pc_t   target;
  } ctrl_t;

  function automatic ctrl_t ucode(input pc_t pc);
    ctrl_t w;
    w = '{take_in: 1'b0, do_mul: 1'b0, do_upd: 1'b0, do_emit: 1'b0,
          cond: COND_NEXT, target: STEP_WAIT};
    case (pc)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_ACCEPT;
        w.target  = STEP_EMIT;
      end
      STEP_MUL: begin
        w.do_mul = 1'b1;
        w.cond   = COND_NEXT;
      end
      STEP_UPD: begin
        w.do_upd = 1'b1;
        w.cond   = COND_LOOP;
        w.target = STEP_MUL;
      end
      STEP_EMIT: begin
        w.do_emit = 1'b1;
        w.cond    = COND_OUT_FREE;
        w.target  = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_OUT_FREE;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic signed [DELAY_W-1:0] sat_delay(
    input logic signed [ACC_W-FRAC_SHIFT-1:0] v
  );
    logic signed [ACC_W-FRAC_SHIFT-1:0] hi;
    logic signed [ACC_W-FRAC_SHIFT-1:0] lo;
    hi = (ACC_W-FRAC_SHIFT)'(32'sh7FFFFFFF);
    lo = (ACC_W-FRAC_SHIFT)'(32'sh80000000);
    if (v > hi) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo) begin
      return 32'sh80000000;
    end
    return v[DELAY_W-1:0];
  endfunction

endpackage

// File: sv/resonator_filter_bank.sv
// Each accepted sample is worked through in turn: one multiplier pair runs a multiply step
// and an update step for each active resonator under a four-step microprogram, and a new
// sample is accepted only after the emit step has loaded the result into the output register.
// A finished result waits in the output register while the next sample is accepted.
// Reset is synchronous: filter_count returns to 1, coefficients and delays to zero,
// and the block is ready for a sample in the first cycle after reset.
module resonator_filter_bank #(
  parameter int MAX_FILTERS = rfb_pkg::MAX_FILTERS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [rfb_pkg::SAMPLE_W-1:0] sample_in,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  output logic signed [rfb_pkg::DELAY_W-1:0]  sum_out,
  output logic                                sum_valid,
  input  logic                                sum_stall,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rfb_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rfb_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int FIDX_W = (MAX_FILTERS > 1) ? $clog2(MAX_FILTERS) : 1;
  localparam int CNT_W  = $clog2(MAX_FILTERS + 1);
  localparam int CMP_W  = CNT_W + 1;
  localparam int SUM_W  = rfb_pkg::DELAY_W + 1 + CNT_W;
  localparam int DW     = rfb_pkg::DELAY_W;
  localparam int AW     = rfb_pkg::ACC_W;
  localparam int PW     = rfb_pkg::PROD_W;

  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(32'sh7FFFFFFF);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(32'sh80000000);

  logic [3:0]                    filter_count;
  logic [rfb_pkg::CFG_DATA_W-1:0] coef_word [rfb_pkg::COEF_WORDS];
  logic signed [DW-1:0]          delay_one [MAX_FILTERS];
  logic signed [DW-1:0]          delay_two [MAX_FILTERS];

  rfb_pkg::pc_t   pc;
  rfb_pkg::pc_t   pc_next;
  rfb_pkg::ctrl_t ctrl;

  logic signed [rfb_pkg::SAMPLE_W-1:0] x;
  logic [FIDX_W-1:0]                   idx;
  logic signed [PW-1:0]                p0;
  logic signed [PW-1:0]                p1;
  logic signed [SUM_W-1:0]             sum;

  logic                          in_take;
  logic                          out_free;
  logic                          cfg_write;
  logic                          cfg_known;
  logic [CNT_W-1:0]              n_eff;
  logic                          n_zero;
  logic                          more;
  logic [rfb_pkg::CFG_DATA_W-1:0] coef_sel;
  logic signed [rfb_pkg::COEF_W-1:0] c0;
  logic signed [rfb_pkg::COEF_W-1:0] c1;
  logic signed [DW-1:0]          y1;
  logic signed [DW-1:0]          y2;
  logic signed [AW-1:0]          acc;
  logic signed [DW-1:0]          y;
  logic signed [DW:0]            diff;
  logic signed [DW-1:0]          sum_sat;

  assign ctrl         = rfb_pkg::ucode(pc);
  assign sample_stall = !ctrl.take_in;
  assign in_take      = sample_valid && ctrl.take_in;
  assign out_free     = !sum_valid || !sum_stall;
  assign cfg_ready    = 1'b1;
  assign cfg_write    = cfg_valid && cfg_ready;
  assign cfg_known    = (cfg_index == rfb_pkg::REG_FILTER_COUNT) ||
                        (cfg_index inside {[rfb_pkg::REG_COEF_FIRST:rfb_pkg::REG_COEF_LAST]});

  always_comb begin
    if (int'(filter_count) > MAX_FILTERS) begin
      n_eff = CNT_W'(MAX_FILTERS);
    end else begin
      n_eff = CNT_W'(filter_count);
    end
    n_zero = (n_eff == '0);
    more   = (CMP_W'(idx) + CMP_W'(1)) < CMP_W'(n_eff);
  end

  always_comb begin
    case (ctrl.cond)
      rfb_pkg::COND_NEXT: begin
        pc_next = pc + 2'd1;
      end
      rfb_pkg::COND_ACCEPT: begin
        if (!in_take) begin
          pc_next = pc;
        end else if (n_zero) begin
          pc_next = ctrl.target;
        end else begin
          pc_next = pc + 2'd1;
        end
      end
      rfb_pkg::COND_LOOP: begin
        pc_next = more ? ctrl.target : pc + 2'd1;
      end
      rfb_pkg::COND_OUT_FREE: begin
        pc_next = out_free ? ctrl.target : pc;
      end
      default: begin
        pc_next = rfb_pkg::STEP_WAIT;
      end
    endcase
  end

  always_comb begin
    coef_sel = '0;
    for (int w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
      if ((32'(idx) >> 1) == 32'(w)) begin
        coef_sel = coef_word[w];
      end
    end
    c0 = idx[0] ? coef_sel[47:32] : coef_sel[15:0];
    c1 = idx[0] ? coef_sel[63:48] : coef_sel[31:16];
    y1 = delay_one[idx];
    y2 = delay_two[idx];
  end

  always_comb begin
    acc  = (AW'(x) <<< rfb_pkg::FRAC_SHIFT) - AW'(p0) - AW'(p1) +
           AW'(rfb_pkg::ROUND_CONST);
    y    = rfb_pkg::sat_delay(acc[AW-1:rfb_pkg::FRAC_SHIFT]);
    diff = (DW+1)'(y) - (DW+1)'(y1);
    if (sum > SUM_MAX) begin
      sum_sat = 32'sh7FFFFFFF;
    end else if (sum < SUM_MIN) begin
      sum_sat = 32'sh80000000;
    end else begin
      sum_sat = sum[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc           <= rfb_pkg::STEP_WAIT;
      sum_valid    <= 1'b0;
      filter_count <= 4'd1;
      for (int w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
        coef_word[w] <= '0;
      end
    end else begin
      pc <= pc_next;
      if (ctrl.do_emit && out_free) begin
        sum_valid <= 1'b1;
      end else if (!sum_stall) begin
        sum_valid <= 1'b0;
      end
      if (cfg_write) begin
        if (cfg_index == rfb_pkg::REG_FILTER_COUNT) begin
          filter_count <= cfg_data[3:0];
        end
        for (int w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
          if (cfg_index == rfb_pkg::REG_COEF_FIRST + rfb_pkg::CFG_IDX_W'(w)) begin
            coef_word[w] <= cfg_data;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_write && cfg_known)) begin
      for (int i = 0; i < MAX_FILTERS; i++) begin
        delay_one[i] <= '0;
        delay_two[i] <= '0;
      end
    end else if (ctrl.do_upd) begin
      delay_one[idx] <= y;
      delay_two[idx] <= y1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      x   <= sample_in;
      idx <= '0;
      sum <= '0;
    end
    if (ctrl.do_mul) begin
      p0 <= c0 * y1;
      p1 <= c1 * y2;
    end
    if (ctrl.do_upd) begin
      sum <= sum + SUM_W'(diff);
      idx <= idx + FIDX_W'(1);
    end
    if (ctrl.do_emit && out_free) begin
      sum_out <= sum_sat;
    end
  end

endmodule

// File: sv/rfb_checker.sv
// Port-level checker for the resonator filter bank and its bind to the top level.
module rfb_checker (
  input logic        clk,
  input logic        rst,
  input logic        sample_valid,
  input logic        sample_stall,
  input logic [31:0] sum_out,
  input logic        sum_valid,
  input logic        sum_stall
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("Sample accepted while the previous one was still in work.");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    (sum_valid && sum_stall) |=> (sum_valid && $stable(sum_out)))
    else $error("Stalled result transaction changed or was dropped.");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(sum_valid) |-> $past(sample_stall))
    else $error("Result appeared without a sample in work.");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!sample_stall && !sum_valid))
    else $error("Block not idle and ready after reset.");

endmodule

bind resonator_filter_bank rfb_checker u_rfb_checker (
  .clk          (clk),
  .rst          (rst),
  .sample_valid (sample_valid),
  .sample_stall (sample_stall),
  .sum_out      (sum_out),
  .sum_valid    (sum_valid),
  .sum_stall    (sum_stall)
);

// File: verif/testbench.sv
// Self-checking testbench for the resonator filter bank with random stalls and config phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FILTERS = rfb_pkg::MAX_FILTERS_DEF;
  localparam logic [rfb_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = rfb_pkg::REG_COEF_LAST + 3'd1;
  localparam logic [rfb_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = rfb_pkg::REG_COEF_LAST + 3'd2;
  localparam longint SUM_MAX = 64'sd2147483647;
  localparam longint SUM_MIN = -64'sd2147483648;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic signed [rfb_pkg::SAMPLE_W-1:0] sample_in = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  logic signed [rfb_pkg::DELAY_W-1:0] sum_out;
  logic sum_valid;
  logic sum_stall = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [rfb_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rfb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  logic [3:0] bank_count;
  logic [rfb_pkg::CFG_DATA_W-1:0] bank_coefs [rfb_pkg::COEF_WORDS];
  longint delay_one [FILTERS];
  longint delay_two [FILTERS];

  logic signed [rfb_pkg::SAMPLE_W-1:0] samples_todo [$];
  logic signed [rfb_pkg::DELAY_W-1:0] sums_due [$];

  int send_odds = 0;
  int recv_odds = 0;
  int send_gap = 0;
  int recv_gap = 0;
  logic hold_off = 1'b0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_cfg = 0;
  int n_in_stalled = 0;
  int n_held = 0;
  int errors = 0;

  resonator_filter_bank dut (
    .clk(clk),
    .rst(rst),
    .sample_in(sample_in),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sum_out(sum_out),
    .sum_valid(sum_valid),
    .sum_stall(sum_stall),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > SUM_MAX) return SUM_MAX;
    if (v < SUM_MIN) return SUM_MIN;
    return v;
  endfunction

  function automatic void clear_bank();
    int i;
    for (i = 0; i < FILTERS; i++) begin
      delay_one[i] = 0;
      delay_two[i] = 0;
    end
  endfunction

  function automatic void bank_reset();
    int w;
    bank_count = 4'd1;
    for (w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
      bank_coefs[w] = '0;
    end
    clear_bank();
  endfunction

  function automatic void bank_write(input logic [rfb_pkg::CFG_IDX_W-1:0] idx,
                                     input logic [rfb_pkg::CFG_DATA_W-1:0] data);
    if (idx == rfb_pkg::REG_FILTER_COUNT) begin
      bank_count = data[3:0];
    end else if (idx inside {[rfb_pkg::REG_COEF_FIRST:rfb_pkg::REG_COEF_LAST]}) begin
      bank_coefs[idx - rfb_pkg::REG_COEF_FIRST] = data;
    end else begin
      return;
    end
    clear_bank();
  endfunction

  // Runs one sample through every active resonator and returns the saturated sum.
  function automatic logic signed [rfb_pkg::DELAY_W-1:0] resonate(
    input logic signed [rfb_pkg::SAMPLE_W-1:0] x
  );
    int n;
    int i;
    logic signed [rfb_pkg::COEF_W-1:0] c0;
    logic signed [rfb_pkg::COEF_W-1:0] c1;
    longint acc;
    longint y;
    longint y1;
    longint y2;
    longint total;
    n = (bank_count > FILTERS) ? FILTERS : int'(bank_count);
    total = 0;
    for (i = 0; i < n; i++) begin
      c0 = bank_coefs[i >> 1][(i & 1) * 32 +: rfb_pkg::COEF_W];
      c1 = bank_coefs[i >> 1][(i & 1) * 32 + rfb_pkg::COEF_W +: rfb_pkg::COEF_W];
      y1 = delay_one[i];
      y2 = delay_two[i];
      acc = longint'(x) * 16384 - longint'(c0) * y1 - longint'(c1) * y2;
      y = clamp32((acc + rfb_pkg::ROUND_CONST) >>> rfb_pkg::FRAC_SHIFT);
      delay_two[i] = y1;
      delay_one[i] = y;
      total += y - y1;
    end
    return rfb_pkg::DELAY_W'(clamp32(total));
  endfunction

  function automatic logic [rfb_pkg::COEF_W-1:0] pick_coef(input bit stable, input bit second);
    int c1;
    int span;
    c1 = $urandom_range(16300, 4000);
    span = 16384 + c1 - 1;
    if (!stable) return rfb_pkg::COEF_W'($urandom);
    if (second) return rfb_pkg::COEF_W'(c1);
    return rfb_pkg::COEF_W'(int'($urandom_range(2 * span, 0)) - span);
  endfunction

  function automatic logic [rfb_pkg::CFG_DATA_W-1:0] pick_coef_word();
    bit stable_a;
    bit stable_b;
    logic [rfb_pkg::COEF_W-1:0] c1_a;
    logic [rfb_pkg::COEF_W-1:0] c1_b;
    stable_a = ($urandom_range(3) != 0);
    stable_b = ($urandom_range(3) != 0);
    if ($urandom_range(7) == 0) return {$urandom, $urandom};
    c1_a = pick_coef(stable_a, 1'b1);
    c1_b = pick_coef(stable_b, 1'b1);
    // A stable c0 is bounded by 1 + c1; reuse the chosen c1 for the bound.
    return {c1_b,
            stable_b ? rfb_pkg::COEF_W'(int'($urandom_range(2 * (16383 + int'(c1_b)), 0))
                                        - (16383 + int'(c1_b)))
                     : rfb_pkg::COEF_W'($urandom),
            c1_a,
            stable_a ? rfb_pkg::COEF_W'(int'($urandom_range(2 * (16383 + int'(c1_a)), 0))
                                        - (16383 + int'(c1_a)))
                     : rfb_pkg::COEF_W'($urandom)};
  endfunction

  function automatic logic signed [rfb_pkg::SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return rfb_pkg::SAMPLE_W'($urandom_range(64)) - 16'sd32;
      default: return rfb_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  task automatic flag_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  task automatic write_reg(input logic [rfb_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rfb_pkg::CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    bank_write(idx, data);
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    do @(posedge clk); while (!(samples_todo.size() == 0 && !sample_valid &&
                                sums_due.size() == 0));
    repeat (2 * FILTERS + 4) @(posedge clk);
  endtask

  task automatic queue_random(input int count);
    repeat (count) samples_todo.push_back(pick_sample());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (sample_valid && sample_stall) n_in_stalled++;
      if (sample_valid && !sample_stall) begin
        sums_due.push_back(resonate(sample_in));
        n_accepted++;
      end
      if (!sample_valid || !sample_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          sample_valid <= 1'b0;
        end else if (send_odds != 0 && $urandom_range(send_odds - 1) == 0) begin
          send_gap = $urandom_range(10, 0);
          sample_valid <= 1'b0;
        end else if (samples_todo.size() > 0) begin
          sample_in <= samples_todo.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [rfb_pkg::DELAY_W-1:0] want;
    logic stall_now;
    if (rst) begin
      sum_stall <= 1'b0;
      recv_gap = 0;
    end else begin
      if (sum_valid && !sum_stall) begin
        if (sums_due.size() == 0) begin
          flag_mismatch($sformatf("sum_out %0d with no sample pending", sum_out));
        end else begin
          want = sums_due.pop_front();
          n_checked++;
          if (sum_out !== want) begin
            flag_mismatch($sformatf("sum_out %0d, expected %0d", sum_out, want));
          end
        end
      end
      if (hold_off) n_held++;
      if (recv_gap > 0) begin
        recv_gap--;
        stall_now = 1'b1;
      end else if (recv_odds != 0 && $urandom_range(recv_odds - 1) == 0) begin
        recv_gap = $urandom_range(10, 0);
        stall_now = 1'b1;
      end else begin
        stall_now = 1'b0;
      end
      sum_stall <= stall_now || hold_off;
    end
  end

  initial begin
    do @(posedge clk); while (!(n_accepted >= 300 && samples_todo.size() > 20));
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int p;
    int w;
    logic [3:0] count_pick;
    bank_reset();
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    samples_todo.push_back(16'sh7FFF);
    samples_todo.push_back(16'sh8000);
    samples_todo.push_back(16'sh0000);
    samples_todo.push_back(16'shFFFF);
    samples_todo.push_back(16'sh0001);
    settle();

    write_reg(rfb_pkg::REG_FILTER_COUNT, 64'hF);
    write_reg(rfb_pkg::REG_COEF_FIRST + 3'd0, 64'h8000_8000_8000_8000);
    write_reg(rfb_pkg::REG_COEF_FIRST + 3'd1, 64'h7FFF_8000_8000_7FFF);
    write_reg(rfb_pkg::REG_COEF_FIRST + 3'd2, 64'h7FFF_7FFF_0000_8000);
    write_reg(rfb_pkg::REG_COEF_FIRST + 3'd3, 64'h8000_0000_7FFF_7FFF);
    write_reg(rfb_pkg::REG_COEF_FIRST + 3'd4, 64'hFFFF_FFFF_FFFF_FFFF);
    repeat (6) samples_todo.push_back(16'sh7FFF);
    settle();

    write_reg(REG_SPARE_LO, {$urandom, $urandom});
    write_reg(REG_SPARE_HI, {$urandom, $urandom});
    repeat (4) samples_todo.push_back(16'sh8000);
    settle();

    write_reg(rfb_pkg::REG_FILTER_COUNT, 64'h0);
    samples_todo.push_back(16'sh5555);
    samples_todo.push_back(16'shAAAA);
    settle();

    write_reg(rfb_pkg::REG_FILTER_COUNT, 64'd10);
    for (w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
      write_reg(rfb_pkg::REG_COEF_FIRST + rfb_pkg::CFG_IDX_W'(w), pick_coef_word());
    end
    queue_random(6);
    settle();

    for (p = 0; p < 12; p++) begin
      if (p == 11) begin
        send_odds <= 0;
        recv_odds <= 0;
      end else begin
        case ($urandom_range(3))
          0: send_odds <= 0;
          1: send_odds <= 3;
          2: send_odds <= 6;
          default: send_odds <= 12;
        endcase
        case ($urandom_range(3))
          0: recv_odds <= 0;
          1: recv_odds <= 3;
          2: recv_odds <= 6;
          default: recv_odds <= 12;
        endcase
      end
      case (p % 6)
        0: count_pick = 4'd10;
        1: count_pick = 4'd0;
        2: count_pick = 4'd15;
        3: count_pick = 4'd1;
        default: count_pick = 4'($urandom_range(15, 0));
      endcase
      write_reg(rfb_pkg::REG_FILTER_COUNT,
                {$urandom, $urandom_range(15, 0) << 4} | 64'(count_pick));
      for (w = 0; w < rfb_pkg::COEF_WORDS; w++) begin
        if (p == 0 || $urandom_range(1) == 0) begin
          write_reg(rfb_pkg::REG_COEF_FIRST + rfb_pkg::CFG_IDX_W'(w), pick_coef_word());
        end
      end
      queue_random(48);
      settle();
      if ($urandom_range(1) == 0) begin
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, {$urandom, $urandom});
      end
      queue_random(48);
      settle();
    end

    $display("Covered %0d samples and %0d results over %0d register writes, counts 0 to 15.",
             n_accepted, n_checked, n_cfg);
    $display("Output held off for %0d cycles; input stalled with a sample waiting %0d cycles.",
             n_held, n_in_stalled);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: resonator_filter_bank.f
sv/rfb_pkg.sv
sv/resonator_filter_bank.sv
sv/rfb_checker.sv
verif/testbench.sv
